// File: rtl/core/mdfp_pkg.sv
// ----------------------------------------------------------------------------
// mdfp_pkg
// Shared types and constants for the motor drive fault protection block.
// ----------------------------------------------------------------------------
package mdfp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int CNT_CFG_W  = 16;
    localparam int CUR_W      = 15;
    localparam int NUM_CH     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BUS_OV    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_UV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PCB_TEMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MTR_TEMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_CNT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_CNT  = 3'd6;

    localparam int CH_OV       = 0;
    localparam int CH_UV       = 1;
    localparam int CH_BOARD_OT = 2;
    localparam int CH_MOTOR_OT = 3;
    localparam int CH_OC       = 4;

    typedef struct packed {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] bus_voltage;
        logic signed [SAMPLE_W-1:0] pcb_temp;
        logic signed [SAMPLE_W-1:0] mtr_temp;
        logic signed [SAMPLE_W-1:0] ph_current;
    } in_item_t;

    typedef struct packed {
        logic [NUM_CH-1:0] fault_bits;
        logic              enable_allowed;
    } out_item_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] bus_ov_limits;
        logic [CFG_DATA_W-1:0] bus_uv_limits;
        logic [CFG_DATA_W-1:0] pcb_temp_limits;
        logic [CFG_DATA_W-1:0] mtr_temp_limits;
        logic [CUR_W-1:0]      current_limit;
        logic [CFG_DATA_W-1:0] fast_counts;
        logic [CFG_DATA_W-1:0] slow_counts;
    } cfg_t;

    typedef struct packed {
        logic upd;
        logic beyond;
        logic recov;
    } chan_ctl_t;

endpackage

// File: rtl/core/mdfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// mdfp_cfg_regs
// Configuration register file: levels, current limit and debounce counts.
// ----------------------------------------------------------------------------
module mdfp_cfg_regs
    import mdfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr) begin
            case (cfg_index)
                REG_BUS_OV:    cfg_reg.bus_ov_limits   <= cfg_data;
                REG_BUS_UV:    cfg_reg.bus_uv_limits   <= cfg_data;
                REG_PCB_TEMP:  cfg_reg.pcb_temp_limits <= cfg_data;
                REG_MTR_TEMP:  cfg_reg.mtr_temp_limits <= cfg_data;
                REG_CUR_LIMIT: cfg_reg.current_limit   <= cfg_data[CUR_W-1:0];
                REG_FAST_CNT:  cfg_reg.fast_counts     <= cfg_data;
                REG_SLOW_CNT:  cfg_reg.slow_counts     <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/mdfp_channel.sv
// ----------------------------------------------------------------------------
// mdfp_channel
// One debounced fault channel: trip and recover counters plus fault flag.
// ----------------------------------------------------------------------------
module mdfp_channel
    import mdfp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  chan_ctl_t            ctl,
    input  logic [CNT_CFG_W-1:0] trig_cnt,
    input  logic [CNT_CFG_W-1:0] rec_cnt,
    output logic                 fault_next
);

    logic [COUNT_WIDTH-1:0] trip_reg, trip_next;
    logic [COUNT_WIDTH-1:0] rec_reg, rec_next;
    logic                   fault_reg;
    logic [COUNT_WIDTH-1:0] trip_bump, rec_bump;
    logic                   trip_hit, rec_hit;

    assign trip_bump = (trip_reg == '1) ? trip_reg
                     : trip_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    assign rec_bump  = (rec_reg == '1) ? rec_reg
                     : rec_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    assign trip_hit  = {{CNT_CFG_W{1'b0}}, trip_bump} >= {{COUNT_WIDTH{1'b0}}, trig_cnt};
    assign rec_hit   = {{CNT_CFG_W{1'b0}}, rec_bump} >= {{COUNT_WIDTH{1'b0}}, rec_cnt};

    always_comb begin
        trip_next  = trip_reg;
        rec_next   = rec_reg;
        fault_next = fault_reg;
        if (ctl.upd) begin
            if (ctl.beyond) begin
                trip_next = trip_bump;
                rec_next  = '0;
                if (trip_hit) begin
                    fault_next = 1'b1;
                end
            end else if (ctl.recov) begin
                if (fault_reg) begin
                    rec_next = rec_bump;
                    if (rec_hit) begin
                        fault_next = 1'b0;
                        trip_next  = '0;
                    end
                end else begin
                    trip_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trip_reg  <= '0;
            rec_reg   <= '0;
            fault_reg <= 1'b0;
        end else begin
            trip_reg  <= trip_next;
            rec_reg   <= rec_next;
            fault_reg <= fault_next;
        end
    end

endmodule

// File: rtl/core/motor_drive_fault_protection.sv
// ----------------------------------------------------------------------------
// motor_drive_fault_protection
// Five-channel debounced fault detector with hysteresis for a motor drive.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result item. An item is captured in an
// input register, then the channel compares and counter updates run and the
// fault bits land in the result register, so one item is taken every clock
// while the output is not stalled. A fast item (mode 0) checks bus over- and
// undervoltage; a slow item (mode 1) checks board and motor temperature and
// overcurrent, the latter with the fast counts. Write configuration only while
// idle.
// ----------------------------------------------------------------------------
module motor_drive_fault_protection
    import mdfp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg;
    in_item_t             in_item_reg;
    logic                 in_valid_reg;
    out_item_t            out_item_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 slow;
    logic [SAMPLE_W:0]    cur_mag;
    logic                 oc;
    chan_ctl_t            ctl [NUM_CH];
    logic [CNT_CFG_W-1:0] trig [NUM_CH];
    logic [CNT_CFG_W-1:0] rec [NUM_CH];
    logic [NUM_CH-1:0]    fault_next;

    mdfp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign slow    = in_item_reg.mode;

    assign cur_mag = in_item_reg.ph_current[SAMPLE_W-1]
                   ? -{in_item_reg.ph_current[SAMPLE_W-1], in_item_reg.ph_current}
                   : {1'b0, in_item_reg.ph_current};
    assign oc      = cur_mag > {{(SAMPLE_W+1-CUR_W){1'b0}}, cfg.current_limit};

    always_comb begin
        ctl[CH_OV].upd          = advance && !slow;
        ctl[CH_OV].beyond       = in_item_reg.bus_voltage
                                > $signed(cfg.bus_ov_limits[31:16]);
        ctl[CH_OV].recov        = in_item_reg.bus_voltage
                                < $signed(cfg.bus_ov_limits[15:0]);
        ctl[CH_UV].upd          = advance && !slow;
        ctl[CH_UV].beyond       = in_item_reg.bus_voltage
                                < $signed(cfg.bus_uv_limits[31:16]);
        ctl[CH_UV].recov        = in_item_reg.bus_voltage
                                > $signed(cfg.bus_uv_limits[15:0]);
        ctl[CH_BOARD_OT].upd    = advance && slow;
        ctl[CH_BOARD_OT].beyond = in_item_reg.pcb_temp
                                > $signed(cfg.pcb_temp_limits[31:16]);
        ctl[CH_BOARD_OT].recov  = in_item_reg.pcb_temp
                                < $signed(cfg.pcb_temp_limits[15:0]);
        ctl[CH_MOTOR_OT].upd    = advance && slow;
        ctl[CH_MOTOR_OT].beyond = in_item_reg.mtr_temp
                                > $signed(cfg.mtr_temp_limits[31:16]);
        ctl[CH_MOTOR_OT].recov  = in_item_reg.mtr_temp
                                < $signed(cfg.mtr_temp_limits[15:0]);
        ctl[CH_OC].upd          = advance && slow;
        ctl[CH_OC].beyond       = oc;
        ctl[CH_OC].recov        = !oc;

        trig[CH_OV]       = cfg.fast_counts[31:16];
        rec[CH_OV]        = cfg.fast_counts[15:0];
        trig[CH_UV]       = cfg.fast_counts[31:16];
        rec[CH_UV]        = cfg.fast_counts[15:0];
        trig[CH_BOARD_OT] = cfg.slow_counts[31:16];
        rec[CH_BOARD_OT]  = cfg.slow_counts[15:0];
        trig[CH_MOTOR_OT] = cfg.slow_counts[31:16];
        rec[CH_MOTOR_OT]  = cfg.slow_counts[15:0];
        trig[CH_OC]       = cfg.fast_counts[31:16];
        rec[CH_OC]        = cfg.fast_counts[15:0];
    end

    for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
        mdfp_channel #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_ch (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl[i]),
            .trig_cnt   (trig[i]),
            .rec_cnt    (rec[i]),
            .fault_next (fault_next[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_item_reg.fault_bits     <= fault_next;
            out_item_reg.enable_allowed <= (fault_next == '0);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
